@@ hw/rtl/sjt_pkg.sv @@
package sjt_pkg;

  // Mark bits held with each joint.
  localparam int MARK_GOAL_BIT  = 0;
  localparam int MARK_GAINS_BIT = 1;
  localparam int MARK_EN_BIT    = 2;

  // One joint of the shadow table as it sits in the memory.
  typedef struct packed {
    logic [2:0]  marks;
    logic [15:0] goal;
    logic [7:0]  p_gain;
    logic [7:0]  i_gain;
    logic [7:0]  d_gain;
  } sjt_entry_t;

  // Contents of a joint that has not been written since reset.
  localparam sjt_entry_t ENTRY_RST = '{
    marks:  3'b000,
    goal:   16'd2048,
    p_gain: 8'h32,
    i_gain: 8'h00,
    d_gain: 8'h00
  };

  // One result segment handed from the sequencer to the output register.
  typedef struct packed {
    logic [1:0]      kind;
    logic            changed;
    logic [2:0]      byte_count;
    logic [6:0][7:0] bytes;
    logic            last;
  } sjt_seg_t;

endpackage

@@ hw/rtl/sjt_table.sv @@
module sjt_table #(
  parameter int JOINT_COUNT = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                rd_en,
  input  logic [$clog2(JOINT_COUNT+1)-1:0]    rd_addr,
  output sjt_pkg::sjt_entry_t                 rd_data,
  input  logic                                wr_en,
  input  logic [$clog2(JOINT_COUNT+1)-1:0]    wr_addr,
  input  sjt_pkg::sjt_entry_t                 wr_data
);

  localparam int DEPTH = JOINT_COUNT + 1;

  sjt_pkg::sjt_entry_t mem [DEPTH];
  sjt_pkg::sjt_entry_t rdat_r;
  logic [DEPTH-1:0]    vld_r;
  logic                rvld_r;

  // Joint memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem[rd_addr];
    end
  end

  // Written marks per joint; an unwritten joint reads as its reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdat_r : sjt_pkg::ENTRY_RST;

endmodule

@@ hw/rtl/sjt_out.sv @@
module sjt_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sjt_pkg::sjt_seg_t seg,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  sjt_pkg::sjt_seg_t seg_r;
  logic              vld_r;
  logic              vld_nxt;

  // The slot is free when empty or when its request leaves this cycle.
  assign free = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (push) begin
      vld_nxt = 1'b1;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      seg_r <= seg;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {4'b0000, seg_r.bytes, seg_r.byte_count, seg_r.changed};
  assign out_tuser  = seg_r.kind;
  assign out_tlast  = seg_r.last;

endmodule

@@ hw/rtl/sjt_ctrl.sv @@
module sjt_ctrl #(
  parameter int JOINT_COUNT = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,
  input  logic [2:0]                          in_tuser,
  output logic                                rd_en,
  output logic [$clog2(JOINT_COUNT+1)-1:0]    rd_addr,
  input  sjt_pkg::sjt_entry_t                 rd_data,
  output logic                                wr_en,
  output logic [$clog2(JOINT_COUNT+1)-1:0]    wr_addr,
  output sjt_pkg::sjt_entry_t                 wr_data,
  output logic                                push,
  output sjt_pkg::sjt_seg_t                   seg,
  input  logic                                free
);

  localparam int IW = $clog2(JOINT_COUNT + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SET   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_HDR   = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_TRAIL = 3'd5;

  localparam logic [2:0] ACT_EN    = 3'd0;
  localparam logic [2:0] ACT_P     = 3'd1;
  localparam logic [2:0] ACT_I     = 3'd2;
  localparam logic [2:0] ACT_D     = 3'd3;
  localparam logic [2:0] ACT_GOAL  = 3'd4;
  localparam logic [2:0] ACT_FLUSH = 3'd5;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_HDR   = 2'd1;
  localparam logic [1:0] KIND_REC   = 2'd2;
  localparam logic [1:0] KIND_TRAIL = 2'd3;

  localparam logic [1:0] FLAGS_GOAL  = 2'b01;
  localparam logic [1:0] FLAGS_GAINS = 2'b10;

  localparam logic [7:0] ADDR_GOAL  = 8'h1E;
  localparam logic [7:0] ADDR_GAINS = 8'h1A;
  localparam logic [7:0] ID_BCAST   = 8'hFE;
  localparam logic [7:0] INS_SYNC   = 8'h83;

  localparam logic [IW-1:0] LAST_IDX = IW'(JOINT_COUNT);

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [2:0]    act_r, act_nxt;
  logic [15:0]   val_r, val_nxt;
  logic          ok_r, ok_nxt;
  logic [1:0]    flags_r, flags_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [7:0]    sum_r, sum_nxt;

  logic [4:0]          in_idx;
  logic                in_ok;
  logic                in_acc;
  sjt_pkg::sjt_entry_t upd;
  logic                upd_chg;
  logic                en;
  logic [7:0]          lo;
  logic [1:0]          sel;
  logic [7:0]          hdr_addr;
  logic [2:0]          plen;
  logic [7:0]          len;
  logic [7:0]          hdr_sum;
  logic [6:0][7:0]     rec;
  logic [2:0]          rec_cnt;
  logic [7:0]          rec_sum;
  logic                emit;

  assign in_idx    = in_tdata[4:0];
  assign in_ok     = (in_idx != 5'd0) && ({27'd0, in_idx} <= 32'(JOINT_COUNT));
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign en        = rd_data.marks[sjt_pkg::MARK_EN_BIT];
  assign lo        = val_r[7:0];

  // Read-modify-write of one joint for a set request.
  always_comb begin
    upd     = rd_data;
    upd_chg = 1'b0;
    case (act_r)
      ACT_EN: begin
        upd.marks[sjt_pkg::MARK_EN_BIT] = (val_r != 16'd0);
      end
      ACT_P: begin
        if (en && rd_data.p_gain != lo) begin
          upd.p_gain = lo;
          upd.marks[sjt_pkg::MARK_GAINS_BIT] = 1'b1;
          upd_chg = 1'b1;
        end
      end
      ACT_I: begin
        if (en && rd_data.i_gain != lo) begin
          upd.i_gain = lo;
          upd.marks[sjt_pkg::MARK_GAINS_BIT] = 1'b1;
          upd_chg = 1'b1;
        end
      end
      ACT_D: begin
        if (en && rd_data.d_gain != lo) begin
          upd.d_gain = lo;
          upd.marks[sjt_pkg::MARK_GAINS_BIT] = 1'b1;
          upd_chg = 1'b1;
        end
      end
      ACT_GOAL: begin
        if (en && rd_data.goal != val_r) begin
          upd.goal = val_r;
          upd.marks[sjt_pkg::MARK_GOAL_BIT] = 1'b1;
          upd_chg = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Frame mode follows from the marks gathered in the scan pass.
  always_comb begin
    if (flags_r == FLAGS_GOAL) begin
      hdr_addr = ADDR_GOAL;
      plen     = 3'd2;
      sel      = 2'b01;
    end else if (flags_r == FLAGS_GAINS) begin
      hdr_addr = ADDR_GAINS;
      plen     = 3'd3;
      sel      = 2'b10;
    end else begin
      hdr_addr = ADDR_GAINS;
      plen     = 3'd6;
      sel      = 2'b11;
    end
    len     = 8'(8'(count_r) * {5'd0, plen + 3'd1} + 8'd4);
    hdr_sum = 8'(ID_BCAST + len + INS_SYNC + hdr_addr + {5'd0, plen});
  end

  // Record of the joint now in the read register.
  always_comb begin
    rec    = '0;
    rec[0] = 8'(cur_r);
    if (plen == 3'd2) begin
      rec[1]  = rd_data.goal[7:0];
      rec[2]  = rd_data.goal[15:8];
      rec_cnt = 3'd3;
    end else begin
      rec[1] = rd_data.d_gain;
      rec[2] = rd_data.i_gain;
      rec[3] = rd_data.p_gain;
      if (plen == 3'd6) begin
        rec[5]  = rd_data.goal[7:0];
        rec[6]  = rd_data.goal[15:8];
        rec_cnt = 3'd7;
      end else begin
        rec_cnt = 3'd4;
      end
    end
    rec_sum = 8'(sum_r + rec[0] + rec[1] + rec[2] + rec[3] + rec[4] + rec[5] + rec[6]);
    emit    = en && ((rd_data.marks[1:0] & sel) != 2'b00);
  end

  // Sequencer: set, scan pass, header, emit pass, trailer.
  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    act_nxt   = act_r;
    val_nxt   = val_r;
    ok_nxt    = ok_r;
    flags_nxt = flags_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    rd_en     = 1'b0;
    rd_addr   = cur_r;
    wr_en     = 1'b0;
    wr_addr   = cur_r;
    wr_data   = upd;
    push      = 1'b0;
    seg       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          act_nxt = in_tuser;
          val_nxt = in_tdata[20:5];
          ok_nxt  = in_ok;
          if (in_tuser == ACT_FLUSH) begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            cur_nxt   = '0;
            flags_nxt = 2'b00;
            count_nxt = '0;
            state_nxt = ST_SCAN;
          end else begin
            rd_en     = in_ok;
            rd_addr   = IW'(in_idx);
            cur_nxt   = IW'(in_idx);
            state_nxt = ST_SET;
          end
        end
      end
      ST_SET: begin
        if (free) begin
          wr_en           = ok_r;
          push            = 1'b1;
          seg.kind        = KIND_ACK;
          seg.changed     = ok_r && upd_chg;
          seg.last        = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (en && rd_data.marks[1:0] != 2'b00) begin
          flags_nxt = flags_r | rd_data.marks[1:0];
          count_nxt = IW'(count_r + 1'b1);
        end
        if (cur_r == LAST_IDX) begin
          state_nxt = ST_HDR;
        end else begin
          rd_en   = 1'b1;
          rd_addr = IW'(cur_r + 1'b1);
          cur_nxt = IW'(cur_r + 1'b1);
        end
      end
      ST_HDR: begin
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (free) begin
          push           = 1'b1;
          seg.kind       = KIND_HDR;
          seg.byte_count = 3'd7;
          seg.bytes      = {{5'd0, plen}, hdr_addr, INS_SYNC, len, ID_BCAST, 8'hFF, 8'hFF};
          sum_nxt        = hdr_sum;
          rd_en          = 1'b1;
          rd_addr        = '0;
          cur_nxt        = '0;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit || free) begin
          if (emit) begin
            push                                = 1'b1;
            seg.kind                            = KIND_REC;
            seg.byte_count                      = rec_cnt;
            seg.bytes                           = rec;
            sum_nxt                             = rec_sum;
            wr_en                               = 1'b1;
            wr_data                             = rd_data;
            wr_data.marks                       = '0;
            wr_data.marks[sjt_pkg::MARK_EN_BIT] = 1'b1;
          end
          if (cur_r == LAST_IDX) begin
            state_nxt = ST_TRAIL;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IW'(cur_r + 1'b1);
            cur_nxt = IW'(cur_r + 1'b1);
          end
        end
      end
      ST_TRAIL: begin
        if (free) begin
          push           = 1'b1;
          seg.kind       = KIND_TRAIL;
          seg.byte_count = 3'd1;
          seg.bytes[0]   = ~sum_r;
          seg.last       = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    act_r   <= act_nxt;
    val_r   <= val_nxt;
    ok_r    <= ok_nxt;
    flags_r <= flags_nxt;
    count_r <= count_nxt;
    sum_r   <= sum_nxt;
  end

endmodule

@@ hw/rtl/servo_joint_table_sync_write_unit.sv @@
// Servo joint shadow table with a broadcast sync-write frame builder.
// Input channel (in_*): one request per accepted beat; in_tuser carries the
// action (set enable, set P, I or D gain, set goal, flush), in_tdata the joint
// index and the value. Result channel (out_*): out_tuser gives the segment
// kind (acknowledge, frame header, joint record, checksum trailer), out_tdata
// the changed flag, the byte count and seven frame bytes; out_tlast marks the
// final result of a request.
// A set request is one read-modify-write of the joint memory; its
// acknowledge is pushed from the set state once the output register is free.
// A flush reads every joint once to count marks and pick the frame mode and,
// if a joint is to be sent, again to emit records, one memory read per cycle
// unless the receiver stalls. A flush with nothing to send gives no result.
// One request is worked on at a time; in_tready is high only while idle,
// even if a result still waits in the output register.
// Reset empties the output register and marks every joint as unwritten, so
// it reads as goal 2048, P gain 0x32, I and D gains 0 and no marks.
// When the receiver stalls, the sequencer holds in place until the output
// register frees; nothing is dropped.
module servo_joint_table_sync_write_unit #(
  parameter int JOINT_COUNT = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, from bit 0: joint_index[4:0], value[15:0], zero fill.
  input  logic [23:0] in_tdata,
  // in_tuser, from bit 0: action[2:0].
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, from bit 0: changed, byte_count[2:0], seg_byte0 .. seg_byte6,
  // zero fill.
  output logic [63:0] out_tdata,
  // out_tuser, from bit 0: kind[1:0].
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam int IW = $clog2(JOINT_COUNT + 1);

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  sjt_pkg::sjt_entry_t rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  sjt_pkg::sjt_entry_t wr_data;
  logic                push;
  sjt_pkg::sjt_seg_t   seg;
  logic                free;

  sjt_ctrl #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .seg       (seg),
    .free      (free)
  );

  sjt_table #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sjt_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .seg        (seg),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
